// ===== rtl/core/eltd_pkg.sv =====
// Shared types and constants of the exclusive lock table with deadlock detection.
// Used by eltd_ctrl, eltd_dp and exclusive_lock_table_deadlock_top; no dependencies.
`default_nettype none

package eltd_pkg;

  localparam int MAX_TXNS = 64;
  localparam int TXN_W    = 6;
  localparam int REC_W    = 32;
  localparam int TO_W     = 16;
  localparam int STS_W    = 3;
  localparam int WCNT_W   = 7;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] FN_ACQUIRE = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_TICK    = 2'd2;

  localparam logic [STS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STS_W-1:0] ST_HELD     = 3'd1;
  localparam logic [STS_W-1:0] ST_WAITING  = 3'd2;
  localparam logic [STS_W-1:0] ST_DEADLOCK = 3'd3;
  localparam logic [STS_W-1:0] ST_TIMEOUT  = 3'd4;
  localparam logic [STS_W-1:0] ST_WAKE     = 3'd5;
  localparam logic [STS_W-1:0] ST_RELEASED = 3'd6;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_LSCAN, S_LDEC, S_WALK, S_WALKRD, S_SETWAIT,
    S_WSCAN, S_RDONE, S_FLUSH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PS_NONE, PS_HELD, PS_GRANT, PS_FULL, PS_DL_REQ, PS_DL_HOLD, PS_WAIT, PS_REL
  } push_sel_t;

  typedef struct packed {
    logic      load;
    logic      lscan;
    logic      walk_init;
    logic      walk;
    logic      walk_adv;
    logic      wscan;
    logic      flush;
    push_sel_t push;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       held_self;
    logic       free_found;
    logic       lscan_done;
    logic       walk_hit;
    logic       walk_stop;
    logic       req_victim;
    logic       wscan_done;
  } dp_stat_t;

  typedef struct packed {
    logic [TXN_W-1:0] owner;
    logic [REC_W-1:0] rec;
  } lock_ent_t;

  typedef struct packed {
    logic [TXN_W-1:0] target;
    logic [TO_W-1:0]  count;
  } wait_ent_t;

endpackage

`default_nettype wire

// ===== rtl/core/eltd_ctrl.sv =====
// Sequencer of the lock table: walks each item through scans, chain walk and flush.
// Depends on eltd_pkg; drives eltd_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module eltd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         func,
  input  wire eltd_pkg::dp_stat_t stat,
  output eltd_pkg::dp_cmd_t       cmd,
  output logic                    busy
);

  eltd_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eltd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      eltd_pkg::S_IDLE: begin
        if (start) begin
          priority case (func)
            eltd_pkg::FN_ACQUIRE: state_next = eltd_pkg::S_LSCAN;
            eltd_pkg::FN_RELEASE: state_next = eltd_pkg::S_LSCAN;
            eltd_pkg::FN_TICK:    state_next = eltd_pkg::S_WSCAN;
            default:              state_next = eltd_pkg::S_IDLE;
          endcase
        end
      end
      eltd_pkg::S_LSCAN: begin
        if (stat.func == eltd_pkg::FN_RELEASE) begin
          if (stat.lscan_done) state_next = eltd_pkg::S_WSCAN;
        end else if (stat.hit || stat.lscan_done) begin
          state_next = eltd_pkg::S_LDEC;
        end
      end
      eltd_pkg::S_LDEC: begin
        if (stat.hit && !stat.held_self) state_next = eltd_pkg::S_WALK;
        else                             state_next = eltd_pkg::S_FLUSH;
      end
      eltd_pkg::S_WALK: begin
        if (stat.walk_hit) begin
          state_next = stat.req_victim ? eltd_pkg::S_FLUSH : eltd_pkg::S_SETWAIT;
        end else if (stat.walk_stop) begin
          state_next = eltd_pkg::S_SETWAIT;
        end else begin
          state_next = eltd_pkg::S_WALKRD;
        end
      end
      eltd_pkg::S_WALKRD:  state_next = eltd_pkg::S_WALK;
      eltd_pkg::S_SETWAIT: state_next = eltd_pkg::S_FLUSH;
      eltd_pkg::S_WSCAN: begin
        if (stat.wscan_done) begin
          state_next = (stat.func == eltd_pkg::FN_RELEASE) ? eltd_pkg::S_RDONE
                                                            : eltd_pkg::S_FLUSH;
        end
      end
      eltd_pkg::S_RDONE: state_next = eltd_pkg::S_FLUSH;
      eltd_pkg::S_FLUSH: state_next = eltd_pkg::S_IDLE;
      default:           state_next = eltd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.push = eltd_pkg::PS_NONE;
    busy = (state != eltd_pkg::S_IDLE);
    unique case (state)
      eltd_pkg::S_IDLE:  cmd.load  = start;
      eltd_pkg::S_LSCAN: cmd.lscan = 1'b1;
      eltd_pkg::S_LDEC: begin
        if (stat.hit) begin
          if (stat.held_self) cmd.push = eltd_pkg::PS_HELD;
          else                cmd.walk_init = 1'b1;
        end else if (stat.free_found) begin
          cmd.push = eltd_pkg::PS_GRANT;
        end else begin
          cmd.push = eltd_pkg::PS_FULL;
        end
      end
      eltd_pkg::S_WALK: begin
        if (stat.walk_hit) begin
          cmd.push = stat.req_victim ? eltd_pkg::PS_DL_REQ : eltd_pkg::PS_DL_HOLD;
        end else if (!stat.walk_stop) begin
          cmd.walk = 1'b1;
        end
      end
      eltd_pkg::S_WALKRD:  cmd.walk_adv = 1'b1;
      eltd_pkg::S_SETWAIT: cmd.push = eltd_pkg::PS_WAIT;
      eltd_pkg::S_WSCAN:   cmd.wscan = 1'b1;
      eltd_pkg::S_RDONE:   cmd.push = eltd_pkg::PS_REL;
      eltd_pkg::S_FLUSH:   cmd.flush = 1'b1;
      default: ;
    endcase
  end

  ctrl_walk_ends: assert property (@(posedge clk) disable iff (rst)
    state == eltd_pkg::S_WALKRD |=> state == eltd_pkg::S_WALK)
    else $error("walk read not followed by walk check");

  ctrl_flush_idle: assert property (@(posedge clk) disable iff (rst)
    state == eltd_pkg::S_FLUSH |=> !busy)
    else $error("item did not end after flush");

  ctrl_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> start && !busy)
    else $error("item loaded while busy");

endmodule

`default_nettype wire

// ===== rtl/core/eltd_dp.sv =====
// Datapath of the lock table: lock and waits-for memories, scan counters, chain walk,
// and the one-deep result holding register that marks the final result. Uses eltd_pkg.
`default_nettype none

module eltd_dp #(
  parameter int LOCK_ENTRIES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire eltd_pkg::dp_cmd_t           cmd,
  output eltd_pkg::dp_stat_t               stat,
  input  wire logic [1:0]                  func,
  input  wire logic [eltd_pkg::TXN_W-1:0]  txn,
  input  wire logic [eltd_pkg::REC_W-1:0]  record_id,
  input  wire logic                        cfg_write,
  input  wire logic [eltd_pkg::TO_W-1:0]   cfg_wdata,
  output logic                             result_valid,
  output logic [eltd_pkg::TXN_W-1:0]       target_txn,
  output logic [eltd_pkg::STS_W-1:0]       status,
  output logic [eltd_pkg::TXN_W-1:0]       blocker_txn,
  output logic                             last
);

  localparam int LIW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int LCW = $clog2(LOCK_ENTRIES + 1);
  localparam logic [LCW-1:0] LE_END = LCW'(LOCK_ENTRIES);
  localparam logic [eltd_pkg::WCNT_W-1:0] WT_END = eltd_pkg::WCNT_W'(eltd_pkg::MAX_TXNS);

  logic [eltd_pkg::TO_W-1:0]  wait_timeout;
  logic [1:0]                 func_q;
  logic [eltd_pkg::TXN_W-1:0] txn_q;
  logic [eltd_pkg::REC_W-1:0] rec_q;
  logic [eltd_pkg::TXN_W-1:0] hold_q;
  logic                       hit_q;
  logic                       free_found;
  logic [LIW-1:0]             free_idx;

  logic [LOCK_ENTRIES-1:0]          lock_valid;
  logic [eltd_pkg::MAX_TXNS-1:0]    wait_valid;
  eltd_pkg::lock_ent_t              lock_mem [LOCK_ENTRIES];
  eltd_pkg::wait_ent_t              wait_mem [eltd_pkg::MAX_TXNS];
  eltd_pkg::lock_ent_t              lrd;
  eltd_pkg::wait_ent_t              wrd;

  logic [LCW-1:0]                lcnt;
  logic                          lsv;
  logic                          lpend;
  logic [LIW-1:0]                lpidx;
  logic [eltd_pkg::WCNT_W-1:0]   wcnt;
  logic                          wsv;
  logic                          wpend;
  logic [eltd_pkg::TXN_W-1:0]    wpidx;
  logic [eltd_pkg::TXN_W-1:0]    cur;
  logic [eltd_pkg::TXN_W-1:0]    steps;

  logic                          pend_v;
  logic [eltd_pkg::TXN_W-1:0]    pend_t;
  logic [eltd_pkg::STS_W-1:0]    pend_s;
  logic [eltd_pkg::TXN_W-1:0]    pend_b;

  logic [LIW-1:0]                lidx;
  logic                          lissue;
  logic                          lcheck;
  logic [eltd_pkg::TXN_W-1:0]    widx;
  logic                          wissue;
  logic                          wcheck;
  logic [eltd_pkg::TXN_W-1:0]    wraddr;
  logic                          wake_hit;
  logic                          tmo_hit;
  logic                          tick_dec;
  logic                          wmem_we;
  logic [eltd_pkg::TXN_W-1:0]    wmem_waddr;
  eltd_pkg::wait_ent_t           wmem_wdata;

  logic                          push_v;
  logic [eltd_pkg::TXN_W-1:0]    push_t;
  logic [eltd_pkg::STS_W-1:0]    push_s;
  logic [eltd_pkg::TXN_W-1:0]    push_b;

  assign lidx   = lcnt[LIW-1:0];
  assign lissue = cmd.lscan && !hit_q && (lcnt != LE_END);
  assign lcheck = cmd.lscan && !hit_q && lsv && lpend;
  assign widx   = wcnt[eltd_pkg::TXN_W-1:0];
  assign wissue = cmd.wscan && (wcnt != WT_END);
  assign wcheck = cmd.wscan && wsv && wpend;
  assign wraddr = cmd.walk ? cur : widx;

  assign wake_hit = wcheck && (func_q == eltd_pkg::FN_RELEASE) && (wrd.target == txn_q);
  assign tmo_hit  = wcheck && (func_q == eltd_pkg::FN_TICK) &&
                    (wrd.count <= eltd_pkg::TO_W'(1));
  assign tick_dec = wcheck && (func_q == eltd_pkg::FN_TICK) && !tmo_hit;

  always_comb begin
    wmem_we    = 1'b0;
    wmem_waddr = wpidx;
    wmem_wdata = '{target: wrd.target, count: wrd.count - eltd_pkg::TO_W'(1)};
    if (cmd.push == eltd_pkg::PS_WAIT) begin
      wmem_we    = 1'b1;
      wmem_waddr = txn_q;
      wmem_wdata = '{target: hold_q, count: wait_timeout};
    end else if (tick_dec) begin
      wmem_we = 1'b1;
    end
  end

  always_comb begin
    push_v = 1'b1;
    push_t = txn_q;
    push_s = eltd_pkg::ST_GRANTED;
    push_b = '0;
    unique case (cmd.push)
      eltd_pkg::PS_HELD:    begin push_s = eltd_pkg::ST_HELD; push_b = txn_q; end
      eltd_pkg::PS_GRANT:   push_s = eltd_pkg::ST_GRANTED;
      eltd_pkg::PS_FULL:    push_s = eltd_pkg::ST_FULL;
      eltd_pkg::PS_DL_REQ:  begin push_s = eltd_pkg::ST_DEADLOCK; push_b = hold_q; end
      eltd_pkg::PS_DL_HOLD: begin
        push_t = hold_q;
        push_s = eltd_pkg::ST_DEADLOCK;
        push_b = txn_q;
      end
      eltd_pkg::PS_WAIT:    begin push_s = eltd_pkg::ST_WAITING; push_b = hold_q; end
      eltd_pkg::PS_REL:     push_s = eltd_pkg::ST_RELEASED;
      eltd_pkg::PS_NONE: begin
        push_t = wpidx;
        if (tmo_hit) begin
          push_s = eltd_pkg::ST_TIMEOUT;
          push_b = wrd.target;
        end else begin
          push_s = eltd_pkg::ST_WAKE;
          push_b = txn_q;
        end
        push_v = tmo_hit || wake_hit;
      end
      default: push_v = 1'b0;
    endcase
  end

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk) begin
    lrd <= lock_mem[lidx];
    if (cmd.push == eltd_pkg::PS_GRANT) begin
      lock_mem[free_idx] <= '{owner: txn_q, rec: rec_q};
    end
  end

  always_ff @(posedge clk) begin
    wrd <= wait_mem[wraddr];
    if (wmem_we) begin
      wait_mem[wmem_waddr] <= wmem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_timeout <= eltd_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      wait_timeout <= cfg_wdata;
    end
  end

  // Item registers, scan counters and chain walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q      <= 1'b0;
      free_found <= 1'b0;
      lcnt       <= '0;
      lsv        <= 1'b0;
      wcnt       <= '0;
      wsv        <= 1'b0;
    end else begin
      if (cmd.load) begin
        func_q     <= func;
        txn_q      <= txn;
        rec_q      <= record_id;
        hit_q      <= 1'b0;
        free_found <= 1'b0;
        lcnt       <= '0;
        lsv        <= 1'b0;
        wcnt       <= '0;
        wsv        <= 1'b0;
      end
      if (cmd.lscan && !hit_q) begin
        lsv   <= lissue;
        lpend <= lissue && lock_valid[lidx];
        lpidx <= lidx;
        if (lissue) lcnt <= lcnt + LCW'(1);
        if (lissue && !lock_valid[lidx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= lidx;
        end
        if (lcheck && func_q == eltd_pkg::FN_ACQUIRE && lrd.rec == rec_q) begin
          hit_q  <= 1'b1;
          hold_q <= lrd.owner;
        end
      end
      if (cmd.wscan) begin
        wsv   <= wissue;
        wpend <= wissue && wait_valid[widx];
        wpidx <= widx;
        if (wissue) wcnt <= wcnt + eltd_pkg::WCNT_W'(1);
      end
      if (cmd.walk_init) begin
        cur   <= hold_q;
        steps <= '0;
      end else if (cmd.walk_adv) begin
        cur   <= wrd.target;
        steps <= steps + eltd_pkg::TXN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_valid <= '0;
    end else begin
      if (lcheck && func_q == eltd_pkg::FN_RELEASE && lrd.owner == txn_q) begin
        lock_valid[lpidx] <= 1'b0;
      end
      if (cmd.push == eltd_pkg::PS_GRANT) begin
        lock_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_valid <= '0;
    end else begin
      if (cmd.load && (func == eltd_pkg::FN_ACQUIRE || func == eltd_pkg::FN_RELEASE)) begin
        wait_valid[txn] <= 1'b0;
      end
      if (tmo_hit || wake_hit) begin
        wait_valid[wpidx] <= 1'b0;
      end
      if (cmd.push == eltd_pkg::PS_DL_HOLD) begin
        wait_valid[hold_q] <= 1'b0;
      end
      if (cmd.push == eltd_pkg::PS_WAIT) begin
        wait_valid[txn_q] <= 1'b1;
      end
    end
  end

  // A result is held back one step so that the final one of an item can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (push_v) begin
        if (pend_v) begin
          result_valid <= 1'b1;
          target_txn   <= pend_t;
          status       <= pend_s;
          blocker_txn  <= pend_b;
          last         <= 1'b0;
        end
        pend_v <= 1'b1;
        pend_t <= push_t;
        pend_s <= push_s;
        pend_b <= push_b;
      end else if (cmd.flush) begin
        if (pend_v) begin
          result_valid <= 1'b1;
          target_txn   <= pend_t;
          status       <= pend_s;
          blocker_txn  <= pend_b;
          last         <= 1'b1;
        end
        pend_v <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.func       = func_q;
    stat.hit        = hit_q;
    stat.held_self  = (hold_q == txn_q);
    stat.free_found = free_found;
    stat.lscan_done = (lcnt == LE_END) && !lsv;
    stat.walk_hit   = (cur == txn_q);
    stat.walk_stop  = !wait_valid[cur] || (steps == {eltd_pkg::TXN_W{1'b1}});
    stat.req_victim = (txn_q > hold_q);
    stat.wscan_done = (wcnt == WT_END) && !wsv;
  end

  dp_flush_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> !push_v)
    else $error("result produced in the flush cycle");

  dp_one_scan: assert property (@(posedge clk) disable iff (rst)
    !(cmd.lscan && cmd.wscan) && !(cmd.walk && cmd.wscan))
    else $error("two scans share a cycle");

  dp_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(pend_v))
    else $error("result without a held entry");

endmodule

`default_nettype wire

// ===== rtl/core/exclusive_lock_table_deadlock_top.sv =====
// Top level of the exclusive lock table with waits-for deadlock detection.
// Instantiates eltd_ctrl and eltd_dp; uses eltd_pkg.
`default_nettype none

// Usage: drive func, txn and record_id with start high; the item is taken at an
// edge where busy is low. Acquire (func 0) scans the lock table one entry per
// cycle through the lock memory's registered read port, stopping early at a
// matching record; a record held by another transaction then walks the
// waits-for chain, each step a check state and a read state. Release (func 1)
// scans the whole lock table and then all 64 waiters. Tick (func 2) scans the
// 64 waiters. Results come out on result_valid for one cycle each, together
// with target_txn, status, blocker_txn and last; last marks the final result
// of an item, and an item may give none. The final result of an item comes out
// in the same cycle as busy falls. The receiver cannot hold results off, so
// there is no stall path. The user must write the wait_timeout register with
// cfg_write and cfg_wdata only while busy is low; the block does not enforce
// it. Reset clears all locks and waits and sets wait_timeout to 1000; it needs
// no clearing pass.
module exclusive_lock_table_deadlock_top #(
  parameter int LOCK_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [5:0]  txn,
  input  wire logic [31:0] record_id,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_wdata,
  output logic             result_valid,
  output logic [5:0]       target_txn,
  output logic [2:0]       status,
  output logic [5:0]       blocker_txn,
  output logic             last
);

  eltd_pkg::dp_cmd_t  cmd;
  eltd_pkg::dp_stat_t stat;

  eltd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  eltd_dp #(
    .LOCK_ENTRIES (LOCK_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .txn          (txn),
    .record_id    (record_id),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .target_txn   (target_txn),
    .status       (status),
    .blocker_txn  (blocker_txn),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of exclusive_lock_table_deadlock_top: directed table, then random items.
// A local lock-table predictor supplies the expected results. Depends on eltd_pkg and the RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOCKS = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [5:0] tgt;
    logic [2:0] sts;
    logic [5:0] blk;
    logic       fin;
  } lock_res_t;

  typedef struct {
    logic [1:0]  fn;
    logic [5:0]  id;
    logic [31:0] rec;
    bit          typed;
    lock_res_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = eltd_pkg::FN_TICK;
  logic [5:0] txn = '0;
  logic [31:0] record_id = '0;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic busy, result_valid, last;
  logic [5:0] target_txn, blocker_txn;
  logic [2:0] status;

  // Predictor state.
  logic [15:0] timeout_ticks;
  bit          held_v[LOCKS];
  logic [31:0] held_rec[LOCKS];
  logic [5:0]  held_by[LOCKS];
  bit          waits_v[64];
  logic [5:0]  waits_on[64];
  logic [15:0] waits_left[64];

  lock_res_t expected_results[$];
  lock_res_t item_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int deadlocks_seen = 0;
  int idle_cycles = 0;
  bit quiet_tail = 0;

  exclusive_lock_table_deadlock_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .txn(txn),
    .record_id(record_id), .cfg_write(cfg_write), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .target_txn(target_txn), .status(status),
    .blocker_txn(blocker_txn), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_res(logic [5:0] t, logic [2:0] s, logic [5:0] b);
    lock_res_t r;
    r.tgt = t;
    r.sts = s;
    r.blk = b;
    r.fin = 1'b0;
    item_results.push_back(r);
  endfunction

  function automatic bit chain_hits(logic [5:0] from, logic [5:0] req);
    logic [5:0] cur;
    cur = from;
    for (int k = 0; k < 64; k++) begin
      if (cur == req) return 1;
      if (!waits_v[cur]) return 0;
      cur = waits_on[cur];
    end
    return 0;
  endfunction

  // Computes the results of one item and updates the predicted lock state.
  function automatic void predict_lock_item(logic [1:0] fn, logic [5:0] t, logic [31:0] rec);
    int hit, free_slot;
    logic [5:0] h;
    item_results.delete();
    if (fn == eltd_pkg::FN_TICK) begin
      for (int i = 0; i < 64; i++) begin
        if (waits_v[i]) begin
          if (waits_left[i] <= 1) begin
            waits_v[i] = 0;
            push_res(i[5:0], eltd_pkg::ST_TIMEOUT, waits_on[i]);
          end else begin
            waits_left[i]--;
          end
        end
      end
    end else if (fn == eltd_pkg::FN_RELEASE) begin
      for (int i = 0; i < LOCKS; i++)
        if (held_v[i] && held_by[i] == t) held_v[i] = 0;
      waits_v[t] = 0;
      for (int i = 0; i < 64; i++) begin
        if (waits_v[i] && waits_on[i] == t) begin
          waits_v[i] = 0;
          push_res(i[5:0], eltd_pkg::ST_WAKE, t);
        end
      end
      push_res(t, eltd_pkg::ST_RELEASED, '0);
    end else if (fn == eltd_pkg::FN_ACQUIRE) begin
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < LOCKS; i++) begin
        if (held_v[i]) begin
          if (held_rec[i] == rec) begin
            hit = i;
            break;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      waits_v[t] = 0;
      if (hit >= 0) begin
        h = held_by[hit];
        if (h == t) begin
          push_res(t, eltd_pkg::ST_HELD, t);
        end else if (chain_hits(h, t) && t > h) begin
          push_res(t, eltd_pkg::ST_DEADLOCK, h);
        end else begin
          if (chain_hits(h, t)) begin
            waits_v[h] = 0;
            push_res(h, eltd_pkg::ST_DEADLOCK, t);
          end
          waits_v[t] = 1;
          waits_on[t] = h;
          waits_left[t] = timeout_ticks;
          push_res(t, eltd_pkg::ST_WAITING, h);
        end
      end else if (free_slot < 0) begin
        push_res(t, eltd_pkg::ST_FULL, '0);
      end else begin
        held_v[free_slot] = 1;
        held_rec[free_slot] = rec;
        held_by[free_slot] = t;
        push_res(t, eltd_pkg::ST_GRANTED, '0);
      end
    end
    if (item_results.size() > 0) item_results[item_results.size()-1].fin = 1'b1;
  endfunction

  // Result monitor and idle watchdog.
  always @(posedge clk) begin
    lock_res_t got, want;
    if (!rst && result_valid) begin
      got = '{target_txn, status, blocker_txn, last};
      results_seen++;
      if (status == eltd_pkg::ST_DEADLOCK) deadlocks_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result tgt=%0d sts=%0d blk=%0d last=%0b",
                 $time, got.tgt, got.sts, got.blk, got.fin);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected tgt=%0d sts=%0d blk=%0d last=%0b",
                   $time, want.tgt, want.sts, want.blk, want.fin);
          $display("%0t:          actual   tgt=%0d sts=%0d blk=%0d last=%0b",
                   $time, got.tgt, got.sts, got.blk, got.fin);
        end
      end
    end
    if (rst || result_valid || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic set_timeout(logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    timeout_ticks = v;
  endtask

  // Waits for every expected result, then lets a trailing item finish.
  task automatic drain_block();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Drives one item at the falling edge and holds it until it is accepted.
  // Unless start is kept, it drops for one cycle afterwards outside the quiet tail.
  task automatic send_lock_item(logic [1:0] fn, logic [5:0] t, logic [31:0] rec,
                                bit keep_start);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    func <= fn;
    txn <= t;
    record_id <= rec;
    do @(posedge clk); while (busy);
    predict_lock_item(fn, t, rec);
    foreach (item_results[k]) expected_results.push_back(item_results[k]);
    items_sent++;
    @(negedge clk);
    if (!keep_start && !quiet_tail) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_record();
    unique case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      1: return $urandom();
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  stim_row_t rows[$];

  function automatic void add_row(logic [1:0] fn, logic [5:0] t, logic [31:0] rec,
                                  bit typed, lock_res_t r);
    stim_row_t s;
    s.fn = fn;
    s.id = t;
    s.rec = rec;
    s.typed = typed;
    s.res = r;
    rows.push_back(s);
  endfunction

  initial begin
    int fn_pick;
    lock_res_t none;
    none = '0;
    timeout_ticks = eltd_pkg::TIMEOUT_RESET;
    foreach (held_v[i]) held_v[i] = 0;
    foreach (waits_v[i]) waits_v[i] = 0;

    // Directed rows: extremes, every function, deadlocks and odd selectors.
    add_row(eltd_pkg::FN_ACQUIRE, 6'd0, 32'h0, 1,
            '{6'd0, eltd_pkg::ST_GRANTED, 6'd0, 1'b1});
    add_row(eltd_pkg::FN_ACQUIRE, 6'd63, 32'hFFFF_FFFF, 1,
            '{6'd63, eltd_pkg::ST_GRANTED, 6'd0, 1'b1});
    add_row(eltd_pkg::FN_ACQUIRE, 6'd63, 32'hFFFF_FFFF, 1,
            '{6'd63, eltd_pkg::ST_HELD, 6'd63, 1'b1});
    add_row(eltd_pkg::FN_ACQUIRE, 6'd0, 32'hFFFF_FFFF, 1,
            '{6'd0, eltd_pkg::ST_WAITING, 6'd63, 1'b1});
    // Younger requester closes the loop and is the victim.
    add_row(eltd_pkg::FN_ACQUIRE, 6'd63, 32'h0, 1,
            '{6'd63, eltd_pkg::ST_DEADLOCK, 6'd0, 1'b1});
    add_row(eltd_pkg::FN_ACQUIRE, 6'd5, 32'hAAAA_5555, 0, none);
    add_row(eltd_pkg::FN_ACQUIRE, 6'd9, 32'h5555_AAAA, 0, none);
    add_row(eltd_pkg::FN_ACQUIRE, 6'd9, 32'hAAAA_5555, 0, none);
    // Older requester closes the loop: the holder is aborted.
    add_row(eltd_pkg::FN_ACQUIRE, 6'd5, 32'h5555_AAAA, 0, none);
    add_row(eltd_pkg::FN_TICK, 6'd0, 32'h0, 0, none);
    add_row(2'd3, 6'd7, 32'h1234, 0, none);
    add_row(eltd_pkg::FN_RELEASE, 6'd63, 32'h0, 0, none);
    add_row(eltd_pkg::FN_RELEASE, 6'd9, 32'h0, 0, none);
    add_row(eltd_pkg::FN_RELEASE, 6'd5, 32'h0, 0, none);
    add_row(eltd_pkg::FN_RELEASE, 6'd0, 32'h0, 1,
            '{6'd0, eltd_pkg::ST_RELEASED, 6'd0, 1'b1});
    add_row(eltd_pkg::FN_TICK, 6'd63, 32'hFFFF_FFFF, 0, none);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[r]) begin
      send_lock_item(rows[r].fn, rows[r].id, rows[r].rec, 0);
      if (rows[r].typed && item_results.size() > 0 &&
          item_results[item_results.size()-1] !== rows[r].res) begin
        errors++;
        $display("%0t: row %0d predictor disagrees with table, expected sts=%0d",
                 $time, r, rows[r].res.sts);
      end
    end
    drain_block();

    // Timeout of 0 behaves as 1; then a short one, the maximum, 1 itself and random ones.
    for (int phase = 0; phase < 6; phase++) begin
      drain_block();
      unique case (phase)
        0: set_timeout(16'd0);
        1: set_timeout(16'd3);
        2: set_timeout(16'hFFFF);
        3: set_timeout(16'd1);
        default: set_timeout(16'($urandom_range(2, 12)));
      endcase
      if (phase == 5) quiet_tail = 1;
      for (int n = 0; n < 35; n++) begin
        fn_pick = $urandom_range(0, 19);
        if (fn_pick < 12)
          send_lock_item(eltd_pkg::FN_ACQUIRE, 6'($urandom_range(0, 15)), pick_record(),
                         1'($urandom_range(0, 1)));
        else if (fn_pick < 15)
          send_lock_item(eltd_pkg::FN_RELEASE, 6'($urandom_range(0, 15)), $urandom(), 0);
        else if (fn_pick < 18)
          send_lock_item(eltd_pkg::FN_TICK, 6'($urandom()), $urandom(),
                         1'($urandom_range(0, 1)));
        else if (fn_pick == 18)
          send_lock_item(2'd3, 6'($urandom()), $urandom(), 0);
        else
          send_lock_item(eltd_pkg::FN_ACQUIRE, 6'($urandom()), $urandom(), 0);
      end
      // Fill the table once, in phase 2, so that full results occur.
      if (phase == 2) begin
        for (int n = 0; n < 260; n++)
          send_lock_item(eltd_pkg::FN_ACQUIRE, 6'd40 + n[1:0], 32'h1000_0000 + n, 1);
        for (int k = 0; k < 4; k++)
          send_lock_item(eltd_pkg::FN_RELEASE, 6'd40 + k[1:0], 32'h0, 0);
      end
      start <= 1'b0;
    end

    drain_block();
    $display("Sent %0d items, checked %0d results, %0d of them deadlock aborts.",
             items_sent, results_seen, deadlocks_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
